// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Clocked on clk, disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Antecedent implies consequent in the same cycle.
`define ASRT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
// Antecedent implies consequent in the next cycle.
`define ASRT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// ===== src/dsp_pkg.sv =====
// Package for the DAG shortest path block: constants, codes and state types.
// No dependencies.
package dsp_pkg;
  localparam int MaxNodes   = 64;
  localparam int MaxEdges   = 256;
  localparam int WeightBits = 16;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT  = 2'd0,
    CFG_SOURCE_NODE = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_UPD,
    ST_SEED_RD,
    ST_SEED_CHK,
    ST_POP_RD,
    ST_POP_T,
    ST_POP_N,
    ST_SRC,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    PH_DEG,
    PH_TOPO,
    PH_RELAX
  } phase_t;

  localparam logic signed [31:0] DistMax = 32'sh7fffffff;
  localparam logic signed [31:0] DistMin = -32'sh7fffffff - 32'sh1;
endpackage

// ===== src/dsp_edge_mem.sv =====
// Edge store: tail, head and weight in one synchronous memory with a registered read.
// Depends on dsp_pkg.
module dsp_edge_mem #(
  parameter int MAX_EDGES   = dsp_pkg::MaxEdges,
  parameter int WEIGHT_BITS = dsp_pkg::WeightBits,
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int DW = 12 + WEIGHT_BITS
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/dsp_node_mem.sv =====
// Per-node store: pending in-degree, distance and reached mark, with a registered read.
// Depends on dsp_pkg.
module dsp_node_mem #(
  parameter int MAX_NODES = dsp_pkg::MaxNodes,
  parameter int DW        = 42,
  localparam int AW = $clog2(MAX_NODES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/dag_single_source_shortest_path_top.sv =====
// DAG single-source shortest path engine over a stored edge list.
// s_axis beats carry commands (load one edge, run, clear); m_axis returns one
// beat per node after a run, nodes ascending, tlast on the final node.
// Config: cfg_we/cfg_addr/cfg_wdata writes node_count (0) or source_node (1).
// Load and clear beats are taken one per cycle while idle; a load into a full
// edge store is dropped and edges_dropped stays set until the next clear.
// A run clears node state, counts in-degrees over the stored edges with both
// ends in range, seeds the order with zero in-degree nodes, then scans the
// edges once per ordered node for the topological order and again for relax
// (relax scans from reached nodes only), with an update step per matching
// edge. Each result beat is read from node memory only after the previous
// one is taken.
// s_axis_tready is low from run acceptance until the last result beat is taken.
// A stalled result holds in the output register and the run waits on it.
// Reset (rst, synchronous) empties the edge store, clears the overflow flag
// and sets node_count to 64 and source_node to 0; node memory is cleared at
// the start of every run.
module dag_single_source_shortest_path_top #(
  parameter int MAX_NODES   = dsp_pkg::MaxNodes,
  parameter int MAX_EDGES   = dsp_pkg::MaxEdges,
  parameter int WEIGHT_BITS = dsp_pkg::WeightBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [7:2] edge_from, [13:8] edge_to, [29:14] edge_weight
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] node, [37:6] distance, [38] reachable
  output logic [39:0] m_axis_tdata,
  // [0] graph_has_cycle, [1] edges_dropped
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata
);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EDW = 12 + WEIGHT_BITS;
  localparam int NDW = ECW + 33;

  logic [6:0] node_count;
  logic [5:0] source_node;
  logic [ECW-1:0] edge_total;
  logic overflow_seen;

  // node count clamped
  logic [NCW-1:0] n;
  always_comb begin
    if (node_count == 7'd0) n = NCW'(1);
    else if (32'(node_count) > MAX_NODES) n = NCW'(MAX_NODES);
    else n = NCW'(node_count);
  end

  dsp_pkg::state_t state, state_next;
  dsp_pkg::phase_t phase, phase_next;

  logic [1:0] op;
  assign op = s_axis_tdata[1:0];
  assign s_axis_tready = (state == dsp_pkg::ST_IDLE);
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // walk registers
  logic [NCW-1:0] idx, idx_next;     // node index / order head
  logic [ECW-1:0] eix, eix_next;     // edge index
  logic [NCW-1:0] count, count_next;
  logic [NAW-1:0] u, u_next;
  logic signed [31:0] du, du_next;
  logic [NAW-1:0] vhold, vhold_next;
  logic signed [WEIGHT_BITS-1:0] whold, whold_next;
  logic cycle, cycle_next;

  // edge memory
  logic e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EDW-1:0] e_wdata, e_rdata;
  dsp_edge_mem #(.MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );
  assign e_we = in_acc && (op == dsp_pkg::OP_LOAD) && (32'(edge_total) < MAX_EDGES);
  assign e_waddr = edge_total[EAW-1:0];
  assign e_wdata = {WEIGHT_BITS'(s_axis_tdata[29:14]), s_axis_tdata[13:8],
                    s_axis_tdata[7:2]};
  assign e_raddr = eix[EAW-1:0];

  logic [5:0] e_tail, e_head;
  logic signed [WEIGHT_BITS-1:0] e_w;
  assign e_tail = e_rdata[5:0];
  assign e_head = e_rdata[11:6];
  assign e_w = e_rdata[EDW-1:12];

  // node memory: {deg, reached, dist}
  logic n_we;
  logic [NAW-1:0] n_waddr, n_raddr;
  logic [NDW-1:0] n_wdata, n_rdata;
  dsp_node_mem #(.MAX_NODES(MAX_NODES), .DW(NDW)) u_node (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );
  logic [ECW-1:0] rd_deg;
  logic rd_reach;
  logic signed [31:0] rd_dist;
  assign rd_deg = n_rdata[NDW-1 -: ECW];
  assign rd_reach = n_rdata[32];
  assign rd_dist = n_rdata[31:0];

  // topological order memory
  logic [NAW-1:0] topo [MAX_NODES];
  logic t_we;
  logic [NAW-1:0] t_waddr, t_wdata, t_raddr, t_rdata;
  assign t_waddr = NAW'(count);
  assign t_raddr = NAW'(idx);
  always_ff @(posedge clk) begin
    if (t_we) topo[t_waddr] <= t_wdata;
    t_rdata <= topo[t_raddr];
  end

  // edge counts for this run when both ends are in range (and tail is u when walking)
  logic relevant;
  assign relevant = ({1'b0, e_tail} < 7'(n)) && ({1'b0, e_head} < 7'(n)) &&
                    ((phase == dsp_pkg::PH_DEG) || (NAW'(e_tail) == u));

  // saturating candidate
  logic signed [32:0] sum;
  logic signed [31:0] cand;
  always_comb begin
    sum = 33'(du) + 33'(whold);
    if (sum > 33'(dsp_pkg::DistMax)) cand = dsp_pkg::DistMax;
    else if (sum < 33'(dsp_pkg::DistMin)) cand = dsp_pkg::DistMin;
    else cand = sum[31:0];
  end

  // output register
  logic ov, ov_next;
  logic [39:0] od, od_next;
  logic [1:0] ou, ou_next;
  logic ol, ol_next;
  assign m_axis_tvalid = ov;
  assign m_axis_tdata = od;
  assign m_axis_tuser = ou;
  assign m_axis_tlast = ol;

  always_comb begin
    state_next = state; phase_next = phase;
    idx_next = idx; eix_next = eix; count_next = count; u_next = u; du_next = du;
    vhold_next = vhold; whold_next = whold; cycle_next = cycle;
    ov_next = ov; od_next = od; ou_next = ou; ol_next = ol;
    n_we = 1'b0; n_waddr = vhold; n_wdata = '0; n_raddr = vhold;
    t_we = 1'b0; t_wdata = vhold;
    unique case (state)
      dsp_pkg::ST_IDLE: begin
        if (in_acc && op == dsp_pkg::OP_RUN) begin
          state_next = dsp_pkg::ST_CLR;
          idx_next = '0;
        end
      end
      dsp_pkg::ST_CLR: begin
        n_we = 1'b1; n_waddr = NAW'(idx); n_wdata = '0;
        if (idx + 1'b1 == n) begin
          state_next = dsp_pkg::ST_SCAN_RD; phase_next = dsp_pkg::PH_DEG; eix_next = '0;
        end else idx_next = idx + 1'b1;
      end
      dsp_pkg::ST_SCAN_RD: begin
        if (eix == edge_total) begin
          if (phase == dsp_pkg::PH_DEG) begin
            state_next = dsp_pkg::ST_SEED_RD; idx_next = '0; count_next = '0;
          end else begin
            state_next = dsp_pkg::ST_POP_RD; idx_next = idx + 1'b1;
          end
        end else state_next = dsp_pkg::ST_SCAN_CHK;
      end
      dsp_pkg::ST_SCAN_CHK: begin
        if (relevant) begin
          n_raddr = NAW'(e_head); vhold_next = NAW'(e_head); whold_next = e_w;
          state_next = dsp_pkg::ST_SCAN_UPD;
        end else begin
          eix_next = eix + 1'b1; state_next = dsp_pkg::ST_SCAN_RD;
        end
      end
      dsp_pkg::ST_SCAN_UPD: begin
        eix_next = eix + 1'b1; state_next = dsp_pkg::ST_SCAN_RD;
        if (phase == dsp_pkg::PH_DEG) begin
          n_we = 1'b1; n_wdata = {ECW'(rd_deg + 1'b1), rd_reach, rd_dist};
        end else if (phase == dsp_pkg::PH_TOPO) begin
          if (rd_deg != '0) begin
            n_we = 1'b1; n_wdata = {ECW'(rd_deg - 1'b1), rd_reach, rd_dist};
            if (rd_deg == ECW'(1) && count < n) begin
              t_we = 1'b1; count_next = count + 1'b1;
            end
          end
        end else if (!rd_reach || cand < rd_dist) begin
          n_we = 1'b1; n_wdata = {rd_deg, 1'b1, cand};
        end
      end
      dsp_pkg::ST_SEED_RD: begin
        if (idx == n) begin
          state_next = dsp_pkg::ST_POP_RD; phase_next = dsp_pkg::PH_TOPO; idx_next = '0;
        end else begin
          n_raddr = NAW'(idx); state_next = dsp_pkg::ST_SEED_CHK;
        end
      end
      dsp_pkg::ST_SEED_CHK: begin
        if (rd_deg == '0) begin
          t_we = 1'b1; t_wdata = NAW'(idx); count_next = count + 1'b1;
        end
        idx_next = idx + 1'b1; state_next = dsp_pkg::ST_SEED_RD;
      end
      dsp_pkg::ST_POP_RD: begin
        if (idx == count) begin
          if (phase == dsp_pkg::PH_TOPO) begin
            cycle_next = (count < n); state_next = dsp_pkg::ST_SRC;
          end else begin
            state_next = dsp_pkg::ST_EMIT_RD; idx_next = '0;
          end
        end else state_next = dsp_pkg::ST_POP_T;
      end
      dsp_pkg::ST_POP_T: begin
        u_next = t_rdata; eix_next = '0;
        if (phase == dsp_pkg::PH_TOPO) state_next = dsp_pkg::ST_SCAN_RD;
        else begin
          n_raddr = t_rdata; state_next = dsp_pkg::ST_POP_N;
        end
      end
      dsp_pkg::ST_POP_N: begin
        if (rd_reach) begin
          du_next = rd_dist; state_next = dsp_pkg::ST_SCAN_RD;
        end else begin
          idx_next = idx + 1'b1; state_next = dsp_pkg::ST_POP_RD;
        end
      end
      dsp_pkg::ST_SRC: begin
        if ({1'b0, source_node} < 7'(n)) begin
          n_we = 1'b1; n_waddr = NAW'(source_node);
          n_wdata = {ECW'(0), 1'b1, 32'sd0};
        end
        phase_next = dsp_pkg::PH_RELAX; idx_next = '0; state_next = dsp_pkg::ST_POP_RD;
      end
      dsp_pkg::ST_EMIT_RD: begin
        n_raddr = NAW'(idx); state_next = dsp_pkg::ST_EMIT_LD;
      end
      dsp_pkg::ST_EMIT_LD: begin
        ov_next = 1'b1;
        od_next = {1'b0, rd_reach, rd_reach ? rd_dist : 32'sd0, 6'(idx)};
        ou_next = {overflow_seen, cycle};
        ol_next = (idx + 1'b1 == n);
        state_next = dsp_pkg::ST_EMIT_WAIT;
      end
      dsp_pkg::ST_EMIT_WAIT: begin
        if (m_axis_tready) begin
          ov_next = 1'b0;
          if (ol) state_next = dsp_pkg::ST_IDLE;
          else begin
            idx_next = idx + 1'b1; state_next = dsp_pkg::ST_EMIT_RD;
          end
        end
      end
      default: state_next = dsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsp_pkg::ST_IDLE;
      phase <= dsp_pkg::PH_DEG;
      node_count <= 7'd64;
      source_node <= '0;
      edge_total <= '0;
      overflow_seen <= 1'b0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      ov <= ov_next;
      if (cfg_we) begin
        if (cfg_addr == 1'(dsp_pkg::CFG_NODE_COUNT)) node_count <= cfg_wdata;
        else source_node <= cfg_wdata[5:0];
      end
      if (in_acc && op == dsp_pkg::OP_LOAD) begin
        if (32'(edge_total) < MAX_EDGES) edge_total <= edge_total + 1'b1;
        else overflow_seen <= 1'b1;
      end
      if (in_acc && op == dsp_pkg::OP_CLEAR) begin
        edge_total <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next; eix <= eix_next; count <= count_next; u <= u_next;
    du <= du_next; vhold <= vhold_next; whold <= whold_next; cycle <= cycle_next;
    od <= od_next; ou <= ou_next; ol <= ol_next;
  end
endmodule

// ===== src/dsp_checker.sv =====
// Port-level checker for the DAG shortest path top level, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module dsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `ASRT_IMP(no_in_while_out, m_axis_tvalid, !s_axis_tready)
  `ASRT_NXT(hold_beat, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASRT_IMP(dist_zero_unreach, m_axis_tvalid && !m_axis_tdata[38], m_axis_tdata[37:6] == 32'd0)
  `ASRT_NXT(idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
endmodule

bind dag_single_source_shortest_path_top dsp_checker u_dsp_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// ===== tb/tb_dag_single_source_shortest_path_top.sv =====
// Testbench for the DAG shortest path block: drives load, clear, run and ignored
// beats and config writes, predicts per-node distances and flags, and checks every result beat.
// Depends on dsp_pkg and dag_single_source_shortest_path_top.
`timescale 1ns / 1ps

typedef struct {
  logic [5:0]         node;
  logic signed [31:0] distance;
  logic               reach;
  logic               cyc;
  logic               drop;
  logic               last;
} path_result_t;

class path_scoreboard;
  logic [5:0]  tails[$];
  logic [5:0]  heads[$];
  logic signed [15:0] weights[$];
  bit          overflow;
  int unsigned node_count = 64;
  int unsigned source = 0;
  path_result_t awaited[$];
  int errors;
  int results_seen;
  int runs;

  function void set_reg(dsp_pkg::cfg_idx_t idx, logic [6:0] v);
    if (idx == dsp_pkg::CFG_NODE_COUNT) node_count = v;
    else source = v[5:0];
  endfunction

  function void note_command(logic [31:0] beat);
    dsp_pkg::op_t op;
    op = dsp_pkg::op_t'(beat[1:0]);
    case (op)
      dsp_pkg::OP_LOAD: begin
        if (tails.size() < dsp_pkg::MaxEdges) begin
          tails.insert(tails.size(), beat[7:2]);
          heads.insert(heads.size(), beat[13:8]);
          weights.insert(weights.size(), beat[29:14]);
        end else overflow = 1;
      end
      dsp_pkg::OP_CLEAR: begin
        tails.delete(); heads.delete(); weights.delete();
        overflow = 0;
      end
      dsp_pkg::OP_RUN: compute_distances();
      default: ;
    endcase
  endfunction

  function void compute_distances();
    int n, cnt, u, v;
    int indeg[64];
    int order[64];
    bit reached[64];
    longint best[64];
    longint cand;
    bit cyc;
    path_result_t r;
    n = node_count < 1 ? 1 : (node_count > 64 ? 64 : node_count);
    runs++;
    for (int i = 0; i < 64; i++) begin
      indeg[i] = 0; reached[i] = 0; best[i] = 0;
    end
    foreach (tails[e]) if (tails[e] < n && heads[e] < n) indeg[heads[e]]++;
    cnt = 0;
    for (int i = 0; i < n; i++) if (indeg[i] == 0) order[cnt++] = i;
    for (int h = 0; h < cnt; h++) begin
      u = order[h];
      foreach (tails[e]) begin
        v = heads[e];
        if (tails[e] != u || v >= n || indeg[v] == 0) continue;
        indeg[v]--;
        if (indeg[v] == 0 && cnt < n) order[cnt++] = v;
      end
    end
    cyc = cnt < n;
    if (source < n) reached[source] = 1;
    for (int i = 0; i < cnt; i++) begin
      u = order[i];
      if (!reached[u]) continue;
      foreach (tails[e]) begin
        v = heads[e];
        if (tails[e] != u || v >= n) continue;
        cand = best[u] + longint'(weights[e]);
        if (cand > 64'sd2147483647) cand = 64'sd2147483647;
        if (cand < -64'sd2147483648) cand = -64'sd2147483648;
        if (!reached[v] || cand < best[v]) begin
          best[v] = cand; reached[v] = 1;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      r.node = 6'(k);
      r.distance = reached[k] ? 32'(best[k]) : 32'sd0;
      r.reach = reached[k];
      r.cyc = cyc;
      r.drop = overflow;
      r.last = (k == n - 1);
      awaited.insert(awaited.size(), r);
    end
  endfunction

  function void check_result(logic [39:0] d, logic [1:0] u, logic l);
    path_result_t x;
    results_seen++;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat: node %0d", d[5:0]);
      return;
    end
    x = awaited.pop_front();
    if (d[5:0] !== x.node || d[37:6] !== x.distance || d[38] !== x.reach ||
        u[0] !== x.cyc || u[1] !== x.drop || l !== x.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp node %0d dist %0d r%b c%b d%b l%b, %s",
                 x.node, x.distance, x.reach, x.cyc, x.drop, x.last,
                 $sformatf("got node %0d dist %0d r%b c%b d%b l%b",
                           d[5:0], $signed(d[37:6]), d[38], u[0], u[1], l));
    end
  endfunction
endclass

module tb_dag_single_source_shortest_path_top;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 0;
  logic [0:0]  cfg_addr = '0;
  logic [6:0]  cfg_wdata = '0;

  path_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int beats_sent;

  dag_single_source_shortest_path_top dut (.*);

  always #5 clk = ~clk;

  always begin
    @(posedge clk);
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send(dsp_pkg::op_t op, logic [5:0] from = 0, logic [5:0] to = 0,
                      logic [15:0] w = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, w, to, from, op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(s_axis_tdata);
    beats_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(dsp_pkg::cfg_idx_t idx, logic [6:0] v);
    drain();
    cfg_we <= 1;
    cfg_addr <= 1'(idx);
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  // random DAG mostly forward edges, some noise
  task automatic random_graph(int nodes, int edges);
    int a, b;
    send(dsp_pkg::OP_CLEAR);
    for (int i = 0; i < edges; i++) begin
      a = $urandom_range(nodes - 1);
      b = $urandom_range(nodes - 1);
      if ($urandom_range(9) == 0)
        send(dsp_pkg::op_t'($urandom_range(3)), 6'($urandom), 6'($urandom), 16'($urandom));
      else if (a < b) send(dsp_pkg::OP_LOAD, 6'(a), 6'(b), 16'($urandom));
      else if (a > b)
        send(dsp_pkg::OP_LOAD, 6'(b), 6'(a), 16'($urandom_range(200)) - 16'd100);
      else send(dsp_pkg::OP_LOAD, 6'(a), 6'($urandom), 16'($urandom));
    end
    send(dsp_pkg::OP_RUN);
  endtask

  initial begin
    int nodes;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: empty graph, extremes, cycle, unreached negative edge, ignored opcode
    send(dsp_pkg::OP_RUN);
    send(dsp_pkg::OP_LOAD, 0, 1, 16'h7fff);
    send(dsp_pkg::OP_LOAD, 1, 2, 16'h7fff);
    send(dsp_pkg::OP_LOAD, 0, 3, 16'h8000);
    send(dsp_pkg::OP_LOAD, 3, 63, 16'h8000);
    send(dsp_pkg::OP_LOAD, 0, 2, 16'hffff);
    send(dsp_pkg::OP_LOAD, 4, 5, 16'd1);
    send(dsp_pkg::OP_LOAD, 5, 4, 16'd1);
    send(dsp_pkg::OP_LOAD, 2, 4, 16'd3);
    send(dsp_pkg::OP_LOAD, 10, 11, -16'sd5);
    send(dsp_pkg::OP_LOAD, 63, 62, 16'd7);
    send(dsp_pkg::OP_NONE, 6'h3f, 6'h3f, 16'hffff);
    send(dsp_pkg::OP_RUN);
    write_reg(dsp_pkg::CFG_NODE_COUNT, 7'd12);
    send(dsp_pkg::OP_RUN);
    write_reg(dsp_pkg::CFG_SOURCE_NODE, 7'd63);
    send(dsp_pkg::OP_RUN);
    write_reg(dsp_pkg::CFG_NODE_COUNT, 7'd0);
    send(dsp_pkg::OP_RUN);
    write_reg(dsp_pkg::CFG_NODE_COUNT, 7'd127);
    write_reg(dsp_pkg::CFG_SOURCE_NODE, 7'd0);
    send(dsp_pkg::OP_RUN);
    send(dsp_pkg::OP_CLEAR);
    send(dsp_pkg::OP_RUN);

    // edge store overflow, small node count keeps the run short
    write_reg(dsp_pkg::CFG_NODE_COUNT, 7'd2);
    for (int i = 0; i < 258; i++)
      send(dsp_pkg::OP_LOAD, 6'($urandom), 6'($urandom), 16'($urandom));
    send(dsp_pkg::OP_RUN);
    send(dsp_pkg::OP_CLEAR);
    send(dsp_pkg::OP_LOAD, 0, 1, 16'd9);
    send(dsp_pkg::OP_RUN);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 64; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 64; end
        default: begin send_idle_pct = 22; recv_idle_pct = 22; end
      endcase
      nodes = ($urandom_range(7) == 0) ? 64 : $urandom_range(2, 12);
      write_reg(dsp_pkg::CFG_NODE_COUNT, 7'(nodes));
      write_reg(dsp_pkg::CFG_SOURCE_NODE,
                7'(($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(nodes - 1)));
      for (int g = 0; g < 2; g++) begin
        random_graph(nodes, $urandom_range(2, 5));
        if (ph == 2 && g == 0) hold_cycles = 3000;
      end
    end
    write_reg(dsp_pkg::CFG_NODE_COUNT, 7'd64);
    write_reg(dsp_pkg::CFG_SOURCE_NODE, 7'd63);
    random_graph(64, 12);
    drain();
    repeat (200) @(posedge clk);

    $display("%0d command beats, %0d runs, %0d result beats checked", beats_sent,
             sb.runs, sb.results_seen);
    $display("included edge overflow, cycles, clamped settings and stalled output");
    if (sb.errors == 0 && sb.awaited.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end
endmodule
